FILE: design/cut_edge_unreachable_nodes_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the cut-edge reachability block
// Shared concurrent assertion forms, clocked on the rising edge and
// disabled while the active-low reset is asserted.
// ----------------------------------------------------------------------------
`ifndef CUT_EDGE_UNREACHABLE_NODES_DEFINES_SVH
`define CUT_EDGE_UNREACHABLE_NODES_DEFINES_SVH

// A property that must hold at every clock edge outside reset.
`define CEUN_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// An antecedent that implies a consequent in the same cycle.
`define CEUN_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

FILE: design/ceun_pkg.sv
// ----------------------------------------------------------------------------
// ceun_pkg
// Types and constants shared by the controller, the datapath and the top.
// ----------------------------------------------------------------------------
package ceun_pkg;

  localparam int NodeBits   = 6;
  localparam int CountBits  = 7;
  localparam int NodeLimit  = 64;
  localparam int MaxResults = 63;

  localparam logic [CountBits-1:0] NodeCountReset = 7'd64;

  localparam logic [1:0] OpAddEdge = 2'd0;
  localparam logic [1:0] OpQuery   = 2'd1;
  localparam logic [1:0] OpClear   = 2'd2;

  typedef struct packed {
    logic capture;
    logic clear_graph;
    logic add_a;
    logic add_b;
    logic walk_init;
    logic deq;
    logic row_rd;
    logic row_merge;
    logic enq;
    logic build_pend;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic edge_ok;
    logic queue_empty;
    logic fresh_empty;
    logic pend_empty;
    logic last_emit;
    logic slot_free;
  } status_t;

endpackage

FILE: design/ceun_ctrl.sv
// ----------------------------------------------------------------------------
// ceun_ctrl
// Sequencer for edge adds, graph clears, the breadth-first walk and the
// listing of unreached nodes.
// ----------------------------------------------------------------------------
module ceun_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic [1:0]        opcode_i,
  output logic              in_ready_o,
  input  ceun_pkg::status_t status_i,
  output ceun_pkg::cmd_t    cmd_o
);
  import ceun_pkg::*;

  localparam logic [3:0] StIdle     = 4'd0;
  localparam logic [3:0] StAddA     = 4'd1;
  localparam logic [3:0] StAddB     = 4'd2;
  localparam logic [3:0] StWalkInit = 4'd3;
  localparam logic [3:0] StDeq      = 4'd4;
  localparam logic [3:0] StQueueRd  = 4'd5;
  localparam logic [3:0] StRow      = 4'd6;
  localparam logic [3:0] StEnq      = 4'd7;
  localparam logic [3:0] StEmit     = 4'd8;

  logic [3:0] state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          case (opcode_i)
            OpAddEdge: begin
              cmd_o.capture = 1'b1;
              state_d       = StAddA;
            end
            OpQuery: begin
              cmd_o.capture = 1'b1;
              state_d       = StWalkInit;
            end
            OpClear: begin
              cmd_o.clear_graph = 1'b1;
            end
            default: begin
            end
          endcase
        end
      end
      StAddA: begin
        if (status_i.edge_ok) begin
          cmd_o.add_a = 1'b1;
          state_d     = StAddB;
        end else begin
          state_d = StIdle;
        end
      end
      StAddB: begin
        cmd_o.add_b = 1'b1;
        state_d     = StIdle;
      end
      StWalkInit: begin
        cmd_o.walk_init = 1'b1;
        state_d         = StDeq;
      end
      StDeq: begin
        if (status_i.queue_empty) begin
          cmd_o.build_pend = 1'b1;
          state_d          = StEmit;
        end else begin
          cmd_o.deq = 1'b1;
          state_d   = StQueueRd;
        end
      end
      StQueueRd: begin
        cmd_o.row_rd = 1'b1;
        state_d      = StRow;
      end
      StRow: begin
        cmd_o.row_merge = 1'b1;
        state_d         = StEnq;
      end
      StEnq: begin
        if (status_i.fresh_empty) begin
          state_d = StDeq;
        end else begin
          cmd_o.enq = 1'b1;
        end
      end
      StEmit: begin
        if (status_i.slot_free) begin
          cmd_o.emit = 1'b1;
          if (status_i.pend_empty || status_i.last_emit) begin
            state_d = StIdle;
          end
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

FILE: design/ceun_datapath.sv
// ----------------------------------------------------------------------------
// ceun_datapath
// Adjacency memory with per-row valid bits, walk queue, visited map,
// listing scan and the result register.
// ----------------------------------------------------------------------------
`include "cut_edge_unreachable_nodes_defines.svh"

module ceun_datapath #(
  parameter int NodeSpan = 64
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic [ceun_pkg::NodeBits-1:0]       node_a_i,
  input  logic [ceun_pkg::NodeBits-1:0]       node_b_i,
  input  logic                                cfg_valid_i,
  input  logic [ceun_pkg::CountBits-1:0]      node_count_i,
  output logic                                cfg_ready_o,
  input  ceun_pkg::cmd_t                      cmd_i,
  output ceun_pkg::status_t                   status_o,
  input  logic                                out_ready_i,
  output logic                                out_valid_o,
  output logic [ceun_pkg::NodeBits-1:0]       unreachable_node_o,
  output logic                                none_unreachable_o,
  output logic                                last_o
);
  import ceun_pkg::*;

  localparam int NodeW = $clog2(NodeSpan);
  localparam int PtrW  = $clog2(NodeSpan + 1);

  // Operands of the current item.
  logic [NodeBits-1:0]  a_q, b_q;
  logic [CountBits-1:0] node_count_q;

  // Adjacency rows; a row whose valid bit is low reads as no edges.
  logic [NodeSpan-1:0] adj_mem [NodeSpan];
  logic [NodeSpan-1:0] row_vld_q;
  logic [NodeSpan-1:0] rd_row_q;
  logic                rd_vld_q;

  logic [NodeBits-1:0] q_mem [NodeSpan];
  logic [NodeBits-1:0] u_q;
  logic [PtrW-1:0]     head_q, tail_q;

  logic [NodeSpan-1:0] visited_q, fresh_q, pend_q;
  logic [NodeBits-1:0] emit_cnt_q;

  logic                out_valid_q, none_q, last_q;
  logic [NodeBits-1:0] node_q;

  logic                edge_ok, start_ok;
  logic [NodeBits-1:0] wr_row, wr_col;
  logic [NodeW-1:0]    wr_idx;
  logic [NodeSpan-1:0] wr_onehot, start_onehot;
  logic [NodeSpan-1:0] row_eff, cut_mask, fresh_d, cnt_mask;
  logic [NodeW-1:0]    fresh_sel, pend_sel;
  logic [NodeSpan-1:0] pend_onehot;
  logic                last_emit, slot_free;

  assign edge_ok  = (7'(a_q) < 7'(NodeSpan)) && (7'(b_q) < 7'(NodeSpan));
  assign start_ok = 7'(a_q) < 7'(NodeSpan);

  assign wr_row       = cmd_i.add_a ? a_q : b_q;
  assign wr_col       = cmd_i.add_a ? b_q : a_q;
  assign wr_idx       = wr_row[NodeW-1:0];
  assign wr_onehot    = NodeSpan'(1) << wr_col;
  assign start_onehot = NodeSpan'(1) << a_q;

  // The cut edge is dropped from the row of either endpoint.
  always_comb begin
    for (int j = 0; j < NodeSpan; j++) begin
      cut_mask[j] = ((u_q == a_q) && (NodeBits'(j) == b_q)) ||
                    ((u_q == b_q) && (NodeBits'(j) == a_q));
      cnt_mask[j] = CountBits'(j) < node_count_q;
    end
  end

  assign row_eff = rd_vld_q ? rd_row_q : '0;
  assign fresh_d = row_eff & ~cut_mask & ~visited_q;

  // Lowest set bit of the newly found nodes and of the unreached nodes.
  always_comb begin
    fresh_sel = '0;
    pend_sel  = '0;
    for (int j = NodeSpan - 1; j >= 0; j--) begin
      if (fresh_q[j]) begin
        fresh_sel = NodeW'(j);
      end
      if (pend_q[j]) begin
        pend_sel = NodeW'(j);
      end
    end
  end

  assign pend_onehot = NodeSpan'(1) << pend_sel;
  assign last_emit   = ((pend_q & ~pend_onehot) == '0) ||
                       (emit_cnt_q == NodeBits'(MaxResults - 1));
  assign slot_free   = !out_valid_q || out_ready_i;

  always_comb begin
    status_o             = '0;
    status_o.edge_ok     = edge_ok;
    status_o.queue_empty = head_q == tail_q;
    status_o.fresh_empty = fresh_q == '0;
    status_o.pend_empty  = pend_q == '0;
    status_o.last_emit   = last_emit;
    status_o.slot_free   = slot_free;
  end

  // Memories: single-row writes, registered reads.
  always_ff @(posedge clk_i) begin
    if (cmd_i.add_a || cmd_i.add_b) begin
      if (row_vld_q[wr_idx]) begin
        adj_mem[wr_idx][wr_col[NodeW-1:0]] <= 1'b1;
      end else begin
        adj_mem[wr_idx] <= wr_onehot;
      end
    end
    if (cmd_i.row_rd) begin
      rd_row_q <= adj_mem[u_q[NodeW-1:0]];
    end
    if (cmd_i.walk_init && start_ok) begin
      q_mem[NodeW'(0)] <= a_q;
    end else if (cmd_i.enq) begin
      q_mem[tail_q[NodeW-1:0]] <= NodeBits'(fresh_sel);
    end
    if (cmd_i.deq) begin
      u_q <= q_mem[head_q[NodeW-1:0]];
    end
  end

  // Operand and result payload.
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      a_q <= node_a_i;
      b_q <= node_b_i;
    end
    if (cmd_i.emit) begin
      if (pend_q == '0) begin
        node_q <= '0;
        none_q <= 1'b1;
        last_q <= 1'b1;
      end else begin
        node_q <= NodeBits'(pend_sel);
        none_q <= 1'b0;
        last_q <= last_emit;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_count_q <= NodeCountReset;
      row_vld_q    <= '0;
      rd_vld_q     <= 1'b0;
      head_q       <= '0;
      tail_q       <= '0;
      visited_q    <= '0;
      fresh_q      <= '0;
      pend_q       <= '0;
      emit_cnt_q   <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        node_count_q <= node_count_i;
      end
      if (cmd_i.clear_graph) begin
        row_vld_q <= '0;
      end else if (cmd_i.add_a || cmd_i.add_b) begin
        row_vld_q[wr_idx] <= 1'b1;
      end
      if (cmd_i.row_rd) begin
        rd_vld_q <= row_vld_q[u_q[NodeW-1:0]];
      end
      if (cmd_i.walk_init) begin
        head_q    <= '0;
        tail_q    <= start_ok ? PtrW'(1) : '0;
        visited_q <= start_ok ? start_onehot : '0;
        fresh_q   <= '0;
      end
      if (cmd_i.deq) begin
        head_q <= head_q + PtrW'(1);
      end
      if (cmd_i.row_merge) begin
        visited_q <= visited_q | fresh_d;
        fresh_q   <= fresh_d;
      end
      if (cmd_i.enq) begin
        tail_q             <= tail_q + PtrW'(1);
        fresh_q[fresh_sel] <= 1'b0;
      end
      if (cmd_i.build_pend) begin
        pend_q     <= ~visited_q & cnt_mask;
        emit_cnt_q <= '0;
      end
      if (cmd_i.emit && (pend_q != '0)) begin
        pend_q     <= pend_q & ~pend_onehot;
        emit_cnt_q <= emit_cnt_q + NodeBits'(1);
      end
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign cfg_ready_o        = 1'b1;
  assign out_valid_o        = out_valid_q;
  assign unreachable_node_o = node_q;
  assign none_unreachable_o = none_q;
  assign last_o             = last_q;

  // Every visited node is either already queued or still waiting to be.
  `CEUN_ASSERT(a_visit_count, clk_i, rst_ni, $countones(visited_q) == int'(tail_q) + $countones(fresh_q), "visited map and queue disagree")
  `CEUN_ASSERT(a_tail_bound, clk_i, rst_ni, tail_q <= PtrW'(NodeSpan), "queue tail beyond node span")
  `CEUN_ASSERT(a_head_tail, clk_i, rst_ni, head_q <= tail_q, "queue head passed the tail")
  `CEUN_ASSERT_IMPL(a_none_last, clk_i, rst_ni, out_valid_q && none_q, last_q, "none result without last flag")

endmodule

FILE: design/cut_edge_unreachable_nodes.sv
// ----------------------------------------------------------------------------
// cut_edge_unreachable_nodes
// Undirected graph store with a cut-edge breadth-first reachability query.
// ----------------------------------------------------------------------------
// An edge add is accepted and then, if both endpoints are in range, writes
// each endpoint's row in turn. A graph clear is done in the idle state on
// acceptance, since clearing only drops the row valid bits. A query captures
// its operands and starts the walk. Each node the walk reaches costs a
// walk-queue read, a read of the single-port adjacency memory, a merge into
// the visited map and a check for newly found nodes. Each newly found node
// costs one queue write; a final empty-queue check ends the walk, and each
// result, at least one per query, then passes through the output register,
// held while the output stalls. The next item is taken as soon as the
// controller is back in its idle state, even while the last result waits.
module cut_edge_unreachable_nodes #(
  parameter int MAX_NODES = 64
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [1:0] opcode_i,
  input  logic [5:0] node_a_i,
  input  logic [5:0] node_b_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [5:0] unreachable_node_o,
  output logic       none_unreachable_o,
  output logic       last_o,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [6:0] node_count_i
);
  import ceun_pkg::*;

  localparam int NodeSpan = (MAX_NODES < NodeLimit) ? MAX_NODES : NodeLimit;

  cmd_t    cmd;
  status_t status;

  ceun_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .opcode_i   (opcode_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  ceun_datapath #(
    .NodeSpan (NodeSpan)
  ) u_datapath (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .node_a_i           (node_a_i),
    .node_b_i           (node_b_i),
    .cfg_valid_i        (cfg_valid_i),
    .node_count_i       (node_count_i),
    .cfg_ready_o        (cfg_ready_o),
    .cmd_i              (cmd),
    .status_o           (status),
    .out_ready_i        (out_ready_i),
    .out_valid_o        (out_valid_o),
    .unreachable_node_o (unreachable_node_o),
    .none_unreachable_o (none_unreachable_o),
    .last_o             (last_o)
  );

endmodule

FILE: tb/cut_edge_unreachable_nodes_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// cut_edge_unreachable_nodes_tb
// Drives edge adds, graph clears and cut-edge queries into the reachability
// block under random idling on both channels, predicts the unreachable node
// list of every query with a breadth-first walk of its own, and compares
// each result in order. node_count is changed between phases while idle.
// ----------------------------------------------------------------------------
import ceun_pkg::*;

typedef struct packed {
  logic [5:0] node;
  logic       none_flag;
  logic       last_flag;
} unreach_t;

class reach_scoreboard;
  logic [63:0] adj_rows [64];
  logic [6:0]  node_count;
  unreach_t    pending_nodes [$];
  int          errors;
  int          results_checked;
  int          queries_seen;
  int          items_seen;

  function new();
    for (int r = 0; r < 64; r++) adj_rows[r] = '0;
    node_count      = NodeCountReset;
    errors          = 0;
    results_checked = 0;
    queries_seen    = 0;
    items_seen      = 0;
  endfunction

  function int pending();
    return pending_nodes.size();
  endfunction

  function void set_node_count(logic [6:0] value);
    node_count = value;
  endfunction

  function void report_mismatch(string msg);
    errors++;
    if (errors <= 40) $display("%0t: %s", $time, msg);
    if (errors == 40) $display("%0t: further mismatches are counted only", $time);
  endfunction

  // Walks breadth first from start with the edge start-cut_end left out and
  // queues every node below node_count that was not reached.
  function void list_unreachable(logic [5:0] start, logic [5:0] cut_end);
    logic [63:0] reached;
    logic [63:0] row;
    logic [5:0]  walk [$];
    logic [5:0]  miss [$];
    logic [5:0]  u;
    unreach_t    res;
    int          head;
    int          active;
    queries_seen++;
    reached        = '0;
    reached[start] = 1'b1;
    walk.insert(walk.size(), start);
    head = 0;
    while (head < walk.size()) begin
      u = walk[head];
      head++;
      row = adj_rows[u];
      if (u == start) row[cut_end] = 1'b0;
      if (u == cut_end) row[start] = 1'b0;
      row = row & ~reached;
      for (int v = 0; v < 64; v++) begin
        if (row[v]) begin
          reached[v] = 1'b1;
          walk.insert(walk.size(), 6'(v));
        end
      end
    end
    active = (node_count > 64) ? 64 : int'(node_count);
    for (int i = 0; i < active; i++) begin
      if (!reached[i]) miss.insert(miss.size(), 6'(i));
    end
    if (miss.size() == 0) begin
      res.node      = '0;
      res.none_flag = 1'b1;
      res.last_flag = 1'b1;
      pending_nodes.insert(pending_nodes.size(), res);
    end else begin
      for (int k = 0; k < miss.size(); k++) begin
        res.node      = miss[k];
        res.none_flag = 1'b0;
        res.last_flag = (k == miss.size() - 1);
        pending_nodes.insert(pending_nodes.size(), res);
      end
    end
  endfunction

  function void note_item(logic [1:0] op, logic [5:0] a, logic [5:0] b);
    items_seen++;
    case (op)
      OpAddEdge: begin
        adj_rows[a][b] = 1'b1;
        adj_rows[b][a] = 1'b1;
      end
      OpClear: begin
        for (int r = 0; r < 64; r++) adj_rows[r] = '0;
      end
      OpQuery: list_unreachable(a, b);
      default: ;
    endcase
  endfunction

  function void check_result(logic [5:0] node, logic none_flag, logic last_flag);
    unreach_t want;
    if (pending_nodes.size() == 0) begin
      report_mismatch($sformatf("unexpected result: node %0d none %0b last %0b",
                                node, none_flag, last_flag));
      return;
    end
    want = pending_nodes[0];
    pending_nodes.delete(0);
    results_checked++;
    if (node !== want.node)
      report_mismatch($sformatf("unreachable_node: expected %0d, got %0d",
                                want.node, node));
    if (none_flag !== want.none_flag)
      report_mismatch($sformatf("none_unreachable: expected %0b, got %0b",
                                want.none_flag, none_flag));
    if (last_flag !== want.last_flag)
      report_mismatch($sformatf("last: expected %0b, got %0b (node %0d)",
                                want.last_flag, last_flag, want.node));
  endfunction
endclass

module cut_edge_unreachable_nodes_tb;
  localparam logic [1:0] OpReserved   = 2'd3;
  localparam int         QuietLimit   = 5000;
  localparam int         SettleCycles = 8;
  localparam int         TailCycles   = 400;

  logic       clk_i;
  logic       rst_ni;
  logic       in_valid_i;
  logic       in_ready_o;
  logic [1:0] opcode_i;
  logic [5:0] node_a_i;
  logic [5:0] node_b_i;
  logic       out_valid_o;
  logic       out_ready_i;
  logic [5:0] unreachable_node_o;
  logic       none_unreachable_o;
  logic       last_o;
  logic       cfg_valid_i;
  logic       cfg_ready_o;
  logic [6:0] node_count_i;

  reach_scoreboard sb;
  bit              stall_on;
  int              idle_cycles;
  int              settings_written;
  logic [5:0]      edge_a [$];
  logic [5:0]      edge_b [$];

  cut_edge_unreachable_nodes dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .opcode_i           (opcode_i),
    .node_a_i           (node_a_i),
    .node_b_i           (node_b_i),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .unreachable_node_o (unreachable_node_o),
    .none_unreachable_o (none_unreachable_o),
    .last_o             (last_o),
    .cfg_valid_i        (cfg_valid_i),
    .cfg_ready_o        (cfg_ready_o),
    .node_count_i       (node_count_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(negedge clk_i) begin
    out_ready_i <= (stall_on && $urandom_range(99) < 34) ? 1'b0 : 1'b1;
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i)
      sb.check_result(unreachable_node_o, none_unreachable_o, last_o);
  end

  // Ends the run if no channel completes a handshake for too long.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= QuietLimit) begin
      $display("%0t: no handshake for %0d cycles, %0d results outstanding",
               $time, idle_cycles, sb.pending());
      $display("== FAIL ==");
      $finish;
    end
  end

  function automatic logic [5:0] pick_node(input int hi);
    return 6'($urandom_range(hi, 0));
  endfunction

  task automatic send_item(input logic [1:0] op, input logic [5:0] a, input logic [5:0] b);
    @(negedge clk_i);
    while (stall_on && $urandom_range(99) < 34) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    opcode_i   <= op;
    node_a_i   <= a;
    node_b_i   <= b;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    sb.note_item(op, a, b);
  endtask

  // Holds the sender off until every predicted result has been seen.
  task automatic wait_all_results(input int extra);
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (extra) @(posedge clk_i);
  endtask

  task automatic write_node_count(input logic [6:0] value);
    @(negedge clk_i);
    cfg_valid_i  <= 1'b1;
    node_count_i <= value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    sb.set_node_count(value);
    settings_written++;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic add_edge(input logic [5:0] a, input logic [5:0] b);
    send_item(OpAddEdge, a, b);
    edge_a.insert(edge_a.size(), a);
    edge_b.insert(edge_b.size(), b);
  endtask

  // A query that cuts an edge known to be stored, from either end.
  task automatic query_on_edge();
    int k;
    k = $urandom_range(edge_a.size() - 1);
    if ($urandom_range(1)) send_item(OpQuery, edge_a[k], edge_b[k]);
    else send_item(OpQuery, edge_b[k], edge_a[k]);
  endtask

  task automatic run_phase(input logic [6:0] count, input int n_items);
    int hi;
    int roll;
    int pause_at;
    wait_all_results(SettleCycles);
    write_node_count(count);
    hi = (count == 0 || count > 64) ? 63 : int'(count) - 1;
    edge_a.delete();
    edge_b.delete();
    send_item(OpClear, pick_node(63), pick_node(63));
    pause_at = $urandom_range(n_items - 1, 1);
    for (int i = 0; i < n_items; i++) begin
      if (i == pause_at) wait_all_results(0);
      roll = $urandom_range(99);
      if (roll < 50) begin
        add_edge(pick_node(hi), pick_node(hi));
      end else if (roll < 75 && edge_a.size() > 0) begin
        query_on_edge();
      end else if (roll < 85) begin
        send_item(OpQuery, pick_node(hi), pick_node(63));
      end else if (roll < 92) begin
        add_edge(pick_node(63), pick_node(63));
      end else if (roll < 96) begin
        send_item(OpReserved, pick_node(63), pick_node(63));
      end else begin
        send_item(OpClear, pick_node(63), pick_node(63));
        edge_a.delete();
        edge_b.delete();
      end
    end
  endtask

  // A random spanning tree over all 64 nodes, so that queries with no cut
  // reach everything and cuts split off whole subtrees.
  task automatic build_tree();
    wait_all_results(SettleCycles);
    write_node_count(7'(NodeLimit));
    send_item(OpClear, 6'd0, 6'd0);
    edge_a.delete();
    edge_b.delete();
    for (int i = 1; i < 64; i++) begin
      add_edge(6'(i), pick_node(i - 1));
      if (i % 9 == 0) query_on_edge();
    end
    send_item(OpQuery, 6'd0, 6'd0);
    send_item(OpQuery, pick_node(63), pick_node(63));
    repeat (4) query_on_edge();
  endtask

  initial begin
    sb               = new();
    rst_ni           = 1'b0;
    in_valid_i       = 1'b0;
    opcode_i         = OpAddEdge;
    node_a_i         = '0;
    node_b_i         = '0;
    out_ready_i      = 1'b0;
    cfg_valid_i      = 1'b0;
    node_count_i     = NodeCountReset;
    stall_on         = 1'b1;
    idle_cycles      = 0;
    settings_written = 0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    write_node_count(7'd64);
    send_item(OpQuery, 6'd0, 6'd0);
    send_item(OpAddEdge, 6'd0, 6'd63);
    send_item(OpAddEdge, 6'd63, 6'd63);
    send_item(OpAddEdge, 6'd5, 6'd5);
    send_item(OpAddEdge, 6'd0, 6'd1);
    send_item(OpAddEdge, 6'd1, 6'd2);
    send_item(OpAddEdge, 6'd2, 6'd63);
    send_item(OpReserved, 6'd62, 6'd61);
    // The cut edge lies on a cycle, so the walk still gets around it.
    send_item(OpQuery, 6'd0, 6'd1);
    send_item(OpQuery, 6'd63, 6'd63);
    send_item(OpQuery, 6'd5, 6'd5);
    send_item(OpQuery, 6'd1, 6'd40);
    send_item(OpQuery, 6'd63, 6'd0);
    send_item(OpClear, 6'd0, 6'd0);
    send_item(OpQuery, 6'd63, 6'd0);

    wait_all_results(SettleCycles);
    write_node_count(7'd1);
    send_item(OpQuery, 6'd0, 6'd0);
    send_item(OpAddEdge, 6'd0, 6'd42);
    // Start outside node_count: the cut leaves node 0 alone.
    send_item(OpQuery, 6'd42, 6'd0);
    send_item(OpQuery, 6'd42, 6'd1);
    wait_all_results(SettleCycles);
    write_node_count(7'd0);
    send_item(OpQuery, 6'd0, 6'd0);
    wait_all_results(SettleCycles);
    write_node_count(7'd127);
    send_item(OpQuery, 6'd0, 6'd0);

    run_phase(7'd2, 18);
    run_phase(7'($urandom_range(12, 3)), 20);
    stall_on = 1'b0;
    run_phase(7'($urandom_range(12, 3)), 20);
    stall_on = 1'b1;
    build_tree();
    run_phase(7'd1, 14);
    run_phase(7'd127, 18);
    run_phase(7'd0, 12);
    run_phase(7'($urandom_range(24, 3)), 20);
    run_phase(7'($urandom_range(63, 3)), 20);
    run_phase(7'($urandom_range(126, 65)), 16);

    wait_all_results(TailCycles);
    $display("Covered %0d items with %0d queries; %0d results were checked.",
             sb.items_seen, sb.queries_seen, sb.results_checked);
    $display("node_count was set %0d times, from 0 through 127, with idling on both sides.",
             settings_written);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule
